### rtl/ilid_pkg.sv
package ilid_pkg;

    // Default list capacity
    localparam int ILID_DEPTH = 64;

    // Field widths fixed by the stream format
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    // Command codes on the slave tuser
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_DUMP,
        OP_INSERT,
        OP_UPDATE,
        OP_DELETE,
        OP_NOP
    } t_op;

    // Queued command between front and back
    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } t_item;

endpackage

### rtl/ilid_front.sv
module ilid_front
    import ilid_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [39:0]      i_s_tdata,   // position[6:0], new_value[38:7], zero fill
    input  logic [CMD_W-1:0] i_s_tuser,   // command[2:0]
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output t_item            o_q_item
);

    t_item       r_fifo [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_fill;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_fill;
    logic        push;
    logic        pop;
    t_item       dec_item;

    // Classify the incoming command
    always_comb begin
        dec_item.pos = i_s_tdata[POS_W-1:0];
        dec_item.val = i_s_tdata[POS_W+VAL_W-1:POS_W];
        case (i_s_tuser)
            CMD_CLEAR:  dec_item.op = OP_CLEAR;
            CMD_DUMP:   dec_item.op = OP_DUMP;
            CMD_INSERT: dec_item.op = OP_INSERT;
            CMD_UPDATE: dec_item.op = OP_UPDATE;
            CMD_DELETE: dec_item.op = OP_DELETE;
            default:    dec_item.op = OP_NOP;
        endcase
    end

    assign o_s_tready = (r_fill != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_fill != 2'd0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_item   = r_fifo[r_rd_ptr];

    // Advance queue pointers and fill level
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Hold queued payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= dec_item;
        end
    end

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("queue fill out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd2 && !pop) |=> (r_fill == 2'd2))
        else $error("queue fill changed without a pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers inconsistent with fill");

endmodule

### rtl/ilid_back.sv
module ilid_back
    import ilid_pkg::*;
#(
    parameter int DEPTH = ILID_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_item       i_q_item,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // status[1:0], element[33:2], list_length[40:34], zero fill
    output logic        o_m_tuser,   // element_valid[0]
    output logic        o_m_tlast
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DUMP = 6'b000010,
        S_INS  = 6'b000100,
        S_PUT  = 6'b001000,
        S_DEL  = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_pos, n_pos;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [STAT_W-1:0]   r_status, n_status;

    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [VAL_W-1:0]    r_out_elem, n_out_elem;
    logic                r_out_evalid, n_out_evalid;
    logic [CW-1:0]       r_out_len, n_out_len;
    logic                r_out_last, n_out_last;

    logic [VAL_W-1:0]    r_mem [DEPTH];
    logic [VAL_W-1:0]    r_rd_data;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [VAL_W-1:0]    wr_data;

    logic                out_free;
    logic [CMPW-1:0]     pos_ext, cnt_ext;
    logic [AW-1:0]       pos_a, cnt_m1;

    assign out_free  = !r_out_valid || i_m_tready;
    assign o_q_ready = (r_state == S_IDLE);
    assign pos_ext   = CMPW'(i_q_item.pos);
    assign cnt_ext   = CMPW'(r_count);
    assign pos_a     = pos_ext[AW-1:0];
    assign cnt_m1    = AW'(r_count - CW'(1));

    // Sequence each command over the element store
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_val        = r_val;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_evalid = r_out_evalid;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = r_val;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_pos    = pos_a;
                    n_val    = i_q_item.val;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    case (i_q_item.op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_DUMP: begin
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        OP_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                n_status = ST_BADIDX;
                            end else if (pos_ext == cnt_ext) begin
                                wr_en   = 1'b1;
                                wr_addr = pos_a;
                                wr_data = i_q_item.val;
                                n_count = r_count + CW'(1);
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = cnt_m1;
                                n_idx   = cnt_m1;
                                n_state = S_INS;
                            end
                        end
                        OP_UPDATE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = ST_BADIDX;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = pos_a;
                                wr_data = i_q_item.val;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = ST_BADIDX;
                            end else if (pos_a == cnt_m1) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = pos_a + AW'(1);
                                n_idx   = pos_a + AW'(1);
                                n_state = S_DEL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_elem   = r_rd_data;
                    n_out_evalid = 1'b1;
                    n_out_len    = r_count;
                    n_out_last   = (r_idx == cnt_m1);
                    if (r_idx == cnt_m1) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + AW'(1);
                        n_idx   = r_idx + AW'(1);
                    end
                end
            end
            S_INS: begin
                // Move one element up, walking from the tail down
                wr_en   = 1'b1;
                wr_addr = r_idx + AW'(1);
                wr_data = r_rd_data;
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_val;
                n_count = r_count + CW'(1);
                n_state = S_RESP;
            end
            S_DEL: begin
                // Move one element down, walking toward the tail
                wr_en   = 1'b1;
                wr_addr = r_idx - AW'(1);
                wr_data = r_rd_data;
                if (r_idx == cnt_m1) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_elem   = '0;
                    n_out_evalid = 1'b0;
                    n_out_len    = r_count;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold command and result payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_evalid <= n_out_evalid;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
    end

    // Element store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, LEN_W'(r_out_len), r_out_elem, r_out_status};
    assign o_m_tuser  = r_out_evalid;
    assign o_m_tlast  = r_out_last;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list length beyond capacity");

    a_mid_is_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_out_evalid)
        else $error("non-final result without an element");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_q_valid) |-> !wr_en)
        else $error("store written while idle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_PUT && r_state != S_DEL)
        |=> (r_count == $past(r_count)))
        else $error("length changed outside insert or delete");

endmodule

### rtl/indexed_list_insert_delete.sv
// Indexed list of up to DEPTH signed 32-bit elements with clear, dump, insert,
// update and delete at an index. Commands are queued two deep behind the slave
// port, so a new command is taken while an earlier one is still running; each
// command then runs alone against a single store with one write and one
// registered read per cycle, moving one element per cycle. Insert at an index
// below the length shifts the elements from the tail down to that index up by
// one before it writes the value, and delete below the last index shifts the
// later elements down by one. Dump of a non-empty list gives one beat per
// element, the last one marked by tlast. Every other command gives a single
// beat with tlast set. A stalled master side holds back each beat. Status 1
// flags an index out of range, status 2 an insert into a full list.
module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int DEPTH = ILID_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [39:0]      i_s_tdata,   // position[6:0], new_value[38:7], zero fill
    input  logic [CMD_W-1:0] i_s_tuser,   // command[2:0]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [47:0]      o_m_tdata,   // status[1:0], element[33:2], list_length[40:34], zero fill
    output logic             o_m_tuser,   // element_valid[0]
    output logic             o_m_tlast
);

    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    ilid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_item   (q_item)
    );

    ilid_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_item   (q_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
